// ----- rtl/core/fbem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbem_pkg
// Shared opcodes, result widths and controller/datapath interface types for
// the band energy meter.
// ----------------------------------------------------------------------------
package fbem_pkg;

  localparam int OP_W     = 2;
  localparam int INDEX_W  = 9;
  localparam int ENERGY_W = 63;
  localparam int COUNT_W  = 32;
  localparam int SAT_W    = 32;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic load;
    logic push;
    logic mac_start;
    logic mac_issue;
    logic scale;
    logic square;
    logic accum;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pipe_busy;
  } stat_t;

endpackage

// ----- rtl/core/fbem_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbem_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/fbem_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbem_ctrl
// Sequencer: input/output handshake, tap counter and filter pass phases.
// ----------------------------------------------------------------------------
module fbem_ctrl #(
  parameter int TAP_COUNT = 511
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [fbem_pkg::OP_W-1:0]    in_operation,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  fbem_pkg::stat_t              stat,
  output fbem_pkg::cmd_t               cmd,
  output logic [$clog2(TAP_COUNT)-1:0] mac_tap
);

  localparam int AW = $clog2(TAP_COUNT);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_SQUARE = 3'd4;
  localparam logic [2:0] S_ACCUM  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] tap_r, tap_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accepted;
  logic          blocked;

  assign blocked  = (in_operation == fbem_pkg::OP_FINISH) && out_valid_r && !out_ready;
  assign in_ready = (state_r == S_IDLE) && !blocked;
  assign accepted = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accepted) begin
          unique case (in_operation)
            fbem_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
            end
            fbem_pkg::OP_PUSH: begin
              cmd.push = 1'b1;
              if (stat.full) begin
                cmd.mac_start = 1'b1;
                tap_nxt       = '0;
                state_nxt     = S_MAC;
              end
            end
            fbem_pkg::OP_FINISH: begin
              cmd.finish    = 1'b1;
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (tap_r == AW'(TAP_COUNT - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign mac_tap   = tap_r;

endmodule

// ----- rtl/core/fbem_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbem_datapath
// Coefficient and delay memories, shared MAC, scale/square/accumulate stages
// and the result register.
// ----------------------------------------------------------------------------
module fbem_datapath #(
  parameter int TAP_COUNT   = 511,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbem_pkg::cmd_t                      cmd,
  input  logic [$clog2(TAP_COUNT)-1:0]        mac_tap,
  input  logic [fbem_pkg::INDEX_W-1:0]        in_coef_index,
  input  logic signed [COEF_BITS-1:0]         in_coef_value,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output fbem_pkg::stat_t                     stat,
  output logic [fbem_pkg::ENERGY_W-1:0]       out_energy,
  output logic [fbem_pkg::COUNT_W-1:0]        out_filtered_count,
  output logic                                out_saturated
);

  localparam int AW     = $clog2(TAP_COUNT);
  localparam int FW     = $clog2(TAP_COUNT + 1);
  localparam int IW     = (AW > fbem_pkg::INDEX_W) ? AW : fbem_pkg::INDEX_W;
  localparam int PW     = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = (PW + AW > 64) ? 64 : PW + AW;
  localparam int FRAC   = COEF_BITS - 1;
  localparam int EW     = fbem_pkg::ENERGY_W;
  localparam int CW     = fbem_pkg::COUNT_W;
  localparam int SW     = fbem_pkg::SAT_W;

  logic [IW-1:0]           idx_ext;
  logic                    coef_we;
  logic [COEF_BITS-1:0]    coef_rd;
  logic [SAMPLE_BITS-1:0]  smp_rd;

  logic [AW-1:0]           wp_r, rp_r;
  logic [FW-1:0]           fill_r;
  logic                    rd_v_r, prod_v_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [63:0]      q64;
  logic [63:SW-1]          q_hi;
  logic                    q_sat;
  logic [SW-1:0]           mag_r;
  logic [63:0]             sq_full;
  logic [EW-1:0]           sq_r;
  logic [EW:0]             sum;
  logic [EW-1:0]           energy_r;
  logic [CW-1:0]           count_r;
  logic                    ovf_r;
  logic [EW-1:0]           res_energy_r;
  logic [CW-1:0]           res_count_r;
  logic                    res_sat_r;

  assign idx_ext = IW'(in_coef_index);
  assign coef_we = cmd.load && (idx_ext < IW'(TAP_COUNT));

  fbem_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (TAP_COUNT)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (in_coef_value),
    .raddr (mac_tap),
    .rdata (coef_rd)
  );

  fbem_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAP_COUNT)
  ) u_delay_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wp_r),
    .wdata (in_sample),
    .raddr (rp_r),
    .rdata (smp_rd)
  );

  assign stat.full      = (fill_r == FW'(TAP_COUNT));
  assign stat.pipe_busy = rd_v_r || prod_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      fill_r   <= '0;
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.mac_issue;
      prod_v_r <= rd_v_r;
      if (cmd.push) begin
        wp_r <= (wp_r == AW'(TAP_COUNT - 1)) ? '0 : wp_r + 1'b1;
        if (!stat.full) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  // walk the circular delay line from the newest sample backward
  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      rp_r <= wp_r;
    end else if (cmd.mac_issue) begin
      rp_r <= (rp_r == '0) ? AW'(TAP_COUNT - 1) : rp_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(coef_rd) * $signed(smp_rd);
    if (cmd.mac_start) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign q64   = 64'(acc_r >>> FRAC);
  assign q_hi  = q64[63:SW-1];
  assign q_sat = !((&q_hi) || !(|q_hi));
  assign sq_full = mag_r * mag_r;
  assign sum   = {1'b0, energy_r} + {1'b0, sq_r};

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      if (q_sat) begin
        mag_r <= q64[63] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        mag_r <= q64[63] ? SW'(-q64) : q64[SW-1:0];
      end
    end
    if (cmd.square) begin
      sq_r <= sq_full[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cmd.scale && q_sat) begin
        ovf_r <= 1'b1;
      end
      if (cmd.accum) begin
        if (sum[EW]) begin
          energy_r <= '1;
          ovf_r    <= 1'b1;
        end else begin
          energy_r <= sum[EW-1:0];
        end
        if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        energy_r <= '0;
        count_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_energy_r <= energy_r;
      res_count_r  <= count_r;
      res_sat_r    <= ovf_r;
    end
  end

  assign out_energy         = res_energy_r;
  assign out_filtered_count = res_count_r;
  assign out_saturated      = res_sat_r;

endmodule

// ----- rtl/core/fir_band_energy_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_band_energy_meter
// FIR band energy meter: coefficient loads, sample pushes through a shared
// MAC, saturating squared-output energy sum reported on finish.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   operation, coef_index,
//                                              coef_value, sample
//   out_      output     out_valid / out_ready energy, filtered_count,
//                                              saturated
//
// Load, finish and pushes before the delay line is full are done on acceptance.
// A filtered push runs one tap per cycle through the single MAC reading the
// coefficient and delay memories, then drain, scale, square and accumulate steps.
// Reset leaves both memories unwritten; no clearing pass is run.
// A finish waits while an earlier report is still held on the output.
// ----------------------------------------------------------------------------
module fir_band_energy_meter #(
  parameter int TAP_COUNT   = 511,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fbem_pkg::OP_W-1:0]         in_operation,
  input  logic [fbem_pkg::INDEX_W-1:0]      in_coef_index,
  input  logic signed [COEF_BITS-1:0]       in_coef_value,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fbem_pkg::ENERGY_W-1:0]     out_energy,
  output logic [fbem_pkg::COUNT_W-1:0]      out_filtered_count,
  output logic                              out_saturated
);

  fbem_pkg::cmd_t               cmd;
  fbem_pkg::stat_t              stat;
  logic [$clog2(TAP_COUNT)-1:0] mac_tap;

  fbem_ctrl #(
    .TAP_COUNT (TAP_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd),
    .mac_tap      (mac_tap)
  );

  fbem_datapath #(
    .TAP_COUNT   (TAP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .mac_tap            (mac_tap),
    .in_coef_index      (in_coef_index),
    .in_coef_value      (in_coef_value),
    .in_sample          (in_sample),
    .stat               (stat),
    .out_energy         (out_energy),
    .out_filtered_count (out_filtered_count),
    .out_saturated      (out_saturated)
  );

endmodule

// ----- tb/sv/fbem_energy_sb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbem_energy_sb_pkg
// Scoreboard for the band energy meter. Mirrors the coefficient store, the
// delay line, the saturating energy sum and the filtered-output counter on
// every accepted input transfer, and checks each energy report field by field
// against the oldest pending report.
// ----------------------------------------------------------------------------
package fbem_energy_sb_pkg;
  import fbem_pkg::*;

  localparam int TAPS       = 511;
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 18;
  localparam int FRAC_SHIFT = COEF_W - 1;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [63:0] ENERGY_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint      OUT_MAX     = 64'sd2147483647;
  localparam longint      OUT_MIN     = -64'sd2147483648;

  typedef struct {
    logic [ENERGY_W-1:0] energy;
    logic [COUNT_W-1:0]  count;
    logic                saturated;
  } energy_report_t;

  class band_energy_scoreboard;
    logic signed [COEF_W-1:0]   coef_mem [TAPS];
    logic signed [SAMPLE_W-1:0] taps_hist [TAPS];
    logic [31:0]                pushes;
    logic [63:0]                energy_sum;
    logic [COUNT_W-1:0]         filtered;
    bit                         overflow_seen;
    energy_report_t             pending_reports [$];
    int                         errors;

    function new();
      foreach (coef_mem[k]) coef_mem[k] = '0;
      foreach (taps_hist[k]) taps_hist[k] = '0;
      pushes        = '0;
      energy_sum    = '0;
      filtered      = '0;
      overflow_seen = 1'b0;
      errors        = 0;
    endfunction

    // Sum of magnitudes of the taps that survive the next push.
    function longint held_magnitude();
      longint total;
      total = 0;
      for (int k = 0; k < TAPS - 1; k++)
        total += (taps_hist[k] < 0) ? -longint'(taps_hist[k]) : longint'(taps_hist[k]);
      return total;
    endfunction

    function void accumulate_band_energy();
      longint      acc;
      longint      scaled;
      logic [63:0] mag;
      logic [63:0] square;
      acc = 0;
      for (int k = 0; k < TAPS; k++)
        acc += longint'(coef_mem[k]) * longint'(taps_hist[k]);
      scaled = acc >>> FRAC_SHIFT;
      if (scaled > OUT_MAX) begin
        scaled        = OUT_MAX;
        overflow_seen = 1'b1;
      end else if (scaled < OUT_MIN) begin
        scaled        = OUT_MIN;
        overflow_seen = 1'b1;
      end
      mag    = (scaled < 0) ? 64'(-scaled) : 64'(scaled);
      square = mag * mag;
      if (energy_sum > ENERGY_CEIL - square) begin
        energy_sum    = ENERGY_CEIL;
        overflow_seen = 1'b1;
      end else begin
        energy_sum += square;
      end
      if (filtered != '1) filtered++;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                             logic signed [COEF_W-1:0] cv,
                             logic signed [SAMPLE_W-1:0] smp);
      energy_report_t rep;
      case (op)
        OP_LOAD: begin
          if (idx < TAPS) coef_mem[idx] = cv;
        end
        OP_PUSH: begin
          for (int k = TAPS - 1; k > 0; k--) taps_hist[k] = taps_hist[k-1];
          taps_hist[0] = smp;
          if (pushes >= TAPS) accumulate_band_energy();
          if (pushes != '1) pushes++;
        end
        OP_FINISH: begin
          rep.energy    = energy_sum[ENERGY_W-1:0];
          rep.count     = filtered;
          rep.saturated = overflow_seen;
          pending_reports.push_back(rep);
          energy_sum = '0;
          filtered   = '0;
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_result(logic [ENERGY_W-1:0] energy, logic [COUNT_W-1:0] count,
                      logic saturated);
      energy_report_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("report with none pending: energy=%0d count=%0d sat=%b",
                         energy, count, saturated));
        return;
      end
      want = pending_reports.pop_front();
      if (energy !== want.energy)
        report($sformatf("energy got %0d want %0d", energy, want.energy));
      if (count !== want.count)
        report($sformatf("filtered_count got %0d want %0d", count, want.count));
      if (saturated !== want.saturated)
        report($sformatf("saturated got %b want %b", saturated, want.saturated));
    endtask
  endclass

endpackage

// ----- tb/sv/tb_fir_band_energy_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_band_energy_meter
// Self-checking bench for the band energy meter. Loads the full coefficient
// set, fills the delay line, then runs random loads, pushes and finishes with
// random idling on both channels, a long output hold-off that backs up the
// input, and a closing phase that steers coefficients to force scaled-output
// saturation in both directions and energy-sum saturation.
// ----------------------------------------------------------------------------
module tb_fir_band_energy_meter;
  import fbem_pkg::*;
  import fbem_energy_sb_pkg::*;

  localparam int     RANDOM_ITEMS = 1170;
  localparam longint LOUD_FLOOR   = 64'sd2148532224;

  logic                       clk;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            in_operation  = OP_LOAD;
  logic [INDEX_W-1:0]         in_coef_index = '0;
  logic signed [COEF_W-1:0]   in_coef_value = '0;
  logic signed [SAMPLE_W-1:0] in_sample     = '0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic [ENERGY_W-1:0]        out_energy;
  logic [COUNT_W-1:0]         out_filtered_count;
  logic                       out_saturated;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  band_energy_scoreboard meter_sb;

  fir_band_energy_meter #(
    .TAP_COUNT  (TAPS),
    .SAMPLE_BITS(SAMPLE_W),
    .COEF_BITS  (COEF_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_coef_index     (in_coef_index),
    .in_coef_value     (in_coef_value),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_energy        (out_energy),
    .out_filtered_count(out_filtered_count),
    .out_saturated     (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #40_000_000;
    $display("fir_band_energy_meter regression: fail");
    $finish;
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  task automatic transfer_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                               input logic signed [COEF_W-1:0] cv,
                               input logic signed [SAMPLE_W-1:0] smp);
    if (!calm && $urandom_range(99) < 2) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(600, 1)) @(posedge clk);
    end
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_coef_index <= idx;
    in_coef_value <= cv;
    in_sample     <= smp;
    do @(posedge clk); while (!in_ready);
    meter_sb.note_input(op, idx, cv, smp);
  endtask

  task automatic load_coef(input logic [INDEX_W-1:0] idx, input logic signed [COEF_W-1:0] cv);
    transfer_item(OP_LOAD, idx, cv, SAMPLE_W'($urandom()));
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp);
    transfer_item(OP_PUSH, INDEX_W'($urandom()), COEF_W'($urandom()), smp);
  endtask

  task automatic finish_report();
    transfer_item(OP_FINISH, INDEX_W'($urandom()), COEF_W'($urandom()),
                  SAMPLE_W'($urandom()));
  endtask

  initial begin : result_sink
    int hold_left;
    bit hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      meter_sb.check_result(out_energy, out_filtered_count, out_saturated);
  end

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] s;
    int done;
    int r;
    int k;
    bit aim_up;
    bit x_neg;
    meter_sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    finish_report();
    transfer_item(OP_SPARE, INDEX_W'($urandom()), COEF_W'($urandom()), SAMPLE_W'($urandom()));
    load_coef('1, COEF_MAX);
    load_coef(INDEX_W'(0), COEF_MIN);
    load_coef(INDEX_W'(TAPS - 1), COEF_MAX);
    load_coef(INDEX_W'(1), '0);
    for (k = 2; k < TAPS - 1; k++) load_coef(INDEX_W'(k), pick_coef());

    // hold the output so a queued finish stalls the input
    hold_req <= 1'b1;
    repeat (3) finish_report();

    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);
    push_sample('0);
    for (k = 3; k < TAPS; k++) push_sample(pick_sample());
    finish_report();
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    finish_report();

    done = 0;
    while (done < RANDOM_ITEMS) begin
      calm <= (done >= 300 && done < 450);
      r = $urandom_range(99);
      if (r < 55) begin
        push_sample(pick_sample());
        done++;
      end else if (r < 77) begin
        if ($urandom_range(19) == 0) begin
          load_coef('1, pick_coef());
        end else begin
          load_coef(INDEX_W'($urandom_range(TAPS - 1)), pick_coef());
          done++;
        end
      end else if (r < 90) begin
        finish_report();
        done++;
      end else begin
        transfer_item(OP_SPARE, INDEX_W'($urandom()), COEF_W'($urandom()),
                      SAMPLE_W'($urandom()));
      end
    end
    calm <= 1'b0;

    // build up enough magnitude in the delay line for steered saturation
    while (meter_sb.held_magnitude() + longint'(SAMPLE_MAX) < LOUD_FLOOR)
      push_sample($urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN);
    finish_report();

    for (r = 0; r < 4; r++) begin
      s      = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      aim_up = (r % 2 == 0);
      load_coef(INDEX_W'(0), ((s < 0) ^ aim_up) ? COEF_MAX : COEF_MIN);
      for (k = 1; k < TAPS; k++) begin
        x_neg = meter_sb.taps_hist[k-1] < 0;
        load_coef(INDEX_W'(k), (x_neg ^ aim_up) ? COEF_MAX : COEF_MIN);
      end
      push_sample(s);
      if (r == 0) finish_report();
    end
    finish_report();
    for (k = 0; k < 12; k++) push_sample(pick_sample());
    finish_report();

    in_valid <= 1'b0;
    while (meter_sb.pending_reports.size() != 0) @(posedge clk);
    repeat (TAPS + 64) @(posedge clk);
    if (meter_sb.errors == 0) begin
      $display("fir_band_energy_meter regression: pass");
    end else begin
      $display("fir_band_energy_meter regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fbem_pkg.sv
rtl/core/fbem_ram.sv
rtl/core/fbem_ctrl.sv
rtl/core/fbem_datapath.sv
rtl/core/fir_band_energy_meter.sv
tb/sv/fbem_energy_sb_pkg.sv
tb/sv/tb_fir_band_energy_meter.sv
